/* sv/gregorian_date_arithmetic_macros.svh */
// Assertion macros used by the date arithmetic back end.
`ifndef GREGORIAN_DATE_ARITHMETIC_MACROS_SVH
`define GREGORIAN_DATE_ARITHMETIC_MACROS_SVH

// Check that cons holds in the same cycle as ante; needs clk and rst_n in scope.
`define GDA_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante; needs clk and rst_n in scope.
`define GDA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/gda_pkg.sv */
// Types, constants and calendar helpers for the date arithmetic block.
package gda_pkg;

  localparam int DAY_W  = 5;
  localparam int MON_W  = 4;
  localparam int YEAR_W = 14;
  localparam int CNT_W  = 16;
  localparam int FUNC_W = 2;
  localparam int YQ_W   = 8;   // year / 100
  localparam int YR_W   = 7;   // year % 100
  localparam int YLEN_W = 9;
  localparam int PROD_W = 27;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;

  localparam logic [YEAR_W-1:0] MIN_YEAR     = 14'd1601;
  localparam logic [12:0]       DIV100_MUL   = 13'd5243;
  localparam int                DIV100_SHIFT = 19;
  localparam logic [YR_W-1:0]   YR_LAST      = 7'd99;

  localparam logic [MON_W-1:0]  MON_JAN  = 4'd1;
  localparam logic [MON_W-1:0]  MON_FEB  = 4'd2;
  localparam logic [MON_W-1:0]  MON_APR  = 4'd4;
  localparam logic [MON_W-1:0]  MON_JUN  = 4'd6;
  localparam logic [MON_W-1:0]  MON_SEP  = 4'd9;
  localparam logic [MON_W-1:0]  MON_NOV  = 4'd11;
  localparam logic [MON_W-1:0]  MON_DEC  = 4'd12;
  localparam logic [DAY_W-1:0]  DAY_FIRST = 5'd1;
  localparam logic [DAY_W-1:0]  DAY_LAST  = 5'd31;

  localparam logic [YLEN_W-1:0] YLEN_COMMON = 9'd365;
  localparam logic [YLEN_W-1:0] YLEN_LEAP   = 9'd366;

  // Queue between front and back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_VALIDATE = 2'd0,
    FN_NEXT     = 2'd1,
    FN_ADD      = 2'd2,
    FN_SUB      = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    K_EMIT,
    K_ADD,
    K_SUB
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_SUB,
    ST_EMIT
  } state_t;

  // One classified job handed from front to back.
  typedef struct packed {
    kind_t               kind;
    logic                ok;
    logic [DAY_W-1:0]    day;
    logic [MON_W-1:0]    month;
    logic [YEAR_W-1:0]   year;
    logic [CNT_W-1:0]    count;
    logic [YQ_W-1:0]     yq;
    logic [YR_W-1:0]     yr;
  } entry_t;

  // Leap year from the year and its split into hundreds and remainder.
  function automatic logic is_leap(input logic [YEAR_W-1:0] y,
                                   input logic [YR_W-1:0] yr,
                                   input logic [YQ_W-1:0] yq);
    return (y[1:0] == 2'd0) && ((yr != '0) || (yq[1:0] == 2'd0));
  endfunction

  // Length of a month; codes outside 1 to 12 are screened out elsewhere.
  function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    len = 5'd31;
    if (m == MON_FEB) begin
      len = leap ? 5'd29 : 5'd28;
    end else if ((m == MON_APR) || (m == MON_JUN) || (m == MON_SEP) ||
                 (m == MON_NOV)) begin
      len = 5'd30;
    end
    return len;
  endfunction

endpackage

/* sv/gda_front.sv */
// Front end: takes input words, splits the year by 100, validates and classifies.
module gda_front #(
  parameter int MAX_YEAR = 9999
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  gda_pkg::func_t               in_func,
  input  logic [gda_pkg::DAY_W-1:0]    in_day,
  input  logic [gda_pkg::MON_W-1:0]    in_month,
  input  logic [gda_pkg::YEAR_W-1:0]   in_year,
  input  logic [gda_pkg::CNT_W-1:0]    in_count,
  output logic                         push_valid,
  input  logic                         push_ready,
  output gda_pkg::entry_t              push_entry
);
  import gda_pkg::*;

  localparam logic [YEAR_W-1:0] MAX_Y = YEAR_W'(MAX_YEAR);

  // Stage A: raw input word
  logic                a_v_r;
  func_t               a_func_r;
  logic [DAY_W-1:0]    a_day_r;
  logic [MON_W-1:0]    a_mon_r;
  logic [YEAR_W-1:0]   a_year_r;
  logic [CNT_W-1:0]    a_cnt_r;
  // Stage B: word plus year / 100
  logic                b_v_r;
  func_t               b_func_r;
  logic [DAY_W-1:0]    b_day_r;
  logic [MON_W-1:0]    b_mon_r;
  logic [YEAR_W-1:0]   b_year_r;
  logic [CNT_W-1:0]    b_cnt_r;
  logic [YQ_W-1:0]     b_yq_r;

  logic                a_ready;
  logic                b_ready;
  logic [PROD_W-1:0]   prod;
  logic [YEAR_W:0]     hund;
  logic [YEAR_W:0]     yr_full;
  logic [YR_W-1:0]     yr;
  logic                leap;
  logic [DAY_W-1:0]    dim;
  logic                ok;

  assign b_ready  = !b_v_r || push_ready;
  assign a_ready  = !a_v_r || b_ready;
  assign in_ready = a_ready;

  // Divide by 100 through a reciprocal multiply
  assign prod = PROD_W'(a_year_r) * PROD_W'(DIV100_MUL);

  // Advance the two-stage pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      if (a_ready) begin
        a_v_r <= in_valid;
      end
      if (b_ready) begin
        b_v_r <= a_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && a_ready) begin
      a_func_r <= in_func;
      a_day_r  <= in_day;
      a_mon_r  <= in_month;
      a_year_r <= in_year;
      a_cnt_r  <= in_count;
    end
    if (a_v_r && b_ready) begin
      b_func_r <= a_func_r;
      b_day_r  <= a_day_r;
      b_mon_r  <= a_mon_r;
      b_year_r <= a_year_r;
      b_cnt_r  <= a_cnt_r;
      b_yq_r   <= prod[DIV100_SHIFT +: YQ_W];
    end
  end

  // Remainder by 100 with shift-adds, then leap year and month length
  assign hund    = {1'b0, b_yq_r, 6'b0} + {2'b0, b_yq_r, 5'b0} + {5'b0, b_yq_r, 2'b0};
  assign yr_full = {1'b0, b_year_r} - hund;
  assign yr      = yr_full[YR_W-1:0];
  assign leap    = is_leap(b_year_r, yr, b_yq_r);
  assign dim     = month_days(b_mon_r, leap);
  assign ok      = (b_year_r >= MIN_YEAR) && (b_year_r <= MAX_Y) &&
                   (b_mon_r >= MON_JAN) && (b_mon_r <= MON_DEC) &&
                   (b_day_r >= DAY_FIRST) && (b_day_r <= dim);

  // Classify the job
  always_comb begin
    push_entry.ok    = ok;
    push_entry.day   = b_day_r;
    push_entry.month = b_mon_r;
    push_entry.year  = b_year_r;
    push_entry.count = b_cnt_r;
    push_entry.yq    = b_yq_r;
    push_entry.yr    = yr;
    push_entry.kind  = K_EMIT;
    if (ok) begin
      unique case (b_func_r)
        FN_VALIDATE: push_entry.kind = K_EMIT;
        FN_NEXT: begin
          push_entry.kind  = K_ADD;
          push_entry.count = CNT_W'(1);
        end
        FN_ADD:      push_entry.kind = K_ADD;
        FN_SUB:      push_entry.kind = K_SUB;
        default:     push_entry.kind = K_EMIT;
      endcase
    end
  end

  assign push_valid = b_v_r;

endmodule

/* sv/gda_fifo.sv */
// Short queue of classified jobs between front and back.
module gda_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  gda_pkg::entry_t  push_entry,
  output logic             pop_valid,
  input  logic             pop,
  output gda_pkg::entry_t  pop_entry
);
  import gda_pkg::*;

  entry_t              mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   cnt_r;
  logic                do_push;
  logic                do_pop;

  assign push_ready = (cnt_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_entry  = mem[rd_ptr_r];

  // Pointers wrap naturally: depth is a power of two
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

endmodule

/* sv/gda_back.sv */
// Back end: steps the date by years and months and holds the result word.
`include "gregorian_date_arithmetic_macros.svh"

module gda_back #(
  parameter int MAX_YEAR = 9999
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  gda_pkg::entry_t              q_entry,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [gda_pkg::DAY_W-1:0]    out_day,
  output logic [gda_pkg::MON_W-1:0]    out_month,
  output logic [gda_pkg::YEAR_W-1:0]   out_year,
  output logic                         out_ok
);
  import gda_pkg::*;

  localparam logic [YEAR_W-1:0] MAX_Y = YEAR_W'(MAX_YEAR);

  state_t              st_r, st_nxt;
  logic [DAY_W-1:0]    d_r, d_nxt;
  logic [MON_W-1:0]    m_r, m_nxt;
  logic [YEAR_W-1:0]   y_r, y_nxt;
  logic [YQ_W-1:0]     yq_r, yq_nxt;
  logic [YR_W-1:0]     yr_r, yr_nxt;
  logic [CNT_W-1:0]    rem_r, rem_nxt;
  logic                ok_r, ok_nxt;
  logic [DAY_W-1:0]    org_day_r, org_day_nxt;
  logic [MON_W-1:0]    org_mon_r, org_mon_nxt;
  logic [YEAR_W-1:0]   org_year_r, org_year_nxt;
  logic                ov_r, ov_nxt;
  logic [DAY_W-1:0]    o_day_r, o_day_nxt;
  logic [MON_W-1:0]    o_mon_r, o_mon_nxt;
  logic [YEAR_W-1:0]   o_year_r, o_year_nxt;
  logic                o_ok_r, o_ok_nxt;

  logic                leap;
  logic [DAY_W-1:0]    dim;
  logic [DAY_W-1:0]    dim_prev;
  logic [CNT_W-1:0]    ylen;
  logic [CNT_W-1:0]    to_next;
  logic [CNT_W-1:0]    to_prev;
  logic                at_jan1;
  logic                at_dec31;
  logic [YQ_W-1:0]     yq_inc, yq_dec;
  logic [YR_W-1:0]     yr_inc, yr_dec;
  logic                fail;

  // Calendar facts for the current work date
  assign leap     = is_leap(y_r, yr_r, yq_r);
  assign dim      = month_days(m_r, leap);
  assign dim_prev = month_days(m_r - 1'b1, leap);
  assign ylen     = CNT_W'(leap ? YLEN_LEAP : YLEN_COMMON);
  assign to_next  = CNT_W'(dim) - CNT_W'(d_r) + CNT_W'(1);
  assign to_prev  = CNT_W'(d_r);
  assign at_jan1  = (d_r == DAY_FIRST) && (m_r == MON_JAN);
  assign at_dec31 = (d_r == DAY_LAST) && (m_r == MON_DEC);

  // Keep year / 100 and year % 100 in step with the year
  assign yr_inc = (yr_r == YR_LAST) ? '0 : yr_r + 1'b1;
  assign yq_inc = (yr_r == YR_LAST) ? yq_r + 1'b1 : yq_r;
  assign yr_dec = (yr_r == '0) ? YR_LAST : yr_r - 1'b1;
  assign yq_dec = (yr_r == '0) ? yq_r - 1'b1 : yq_r;

  always_comb begin
    st_nxt       = st_r;
    d_nxt        = d_r;
    m_nxt        = m_r;
    y_nxt        = y_r;
    yq_nxt       = yq_r;
    yr_nxt       = yr_r;
    rem_nxt      = rem_r;
    ok_nxt       = ok_r;
    org_day_nxt  = org_day_r;
    org_mon_nxt  = org_mon_r;
    org_year_nxt = org_year_r;
    ov_nxt       = ov_r && !out_ready;
    o_day_nxt    = o_day_r;
    o_mon_nxt    = o_mon_r;
    o_year_nxt   = o_year_r;
    o_ok_nxt     = o_ok_r;
    q_pop        = 1'b0;
    fail         = 1'b0;

    unique case (st_r)
      // Take the next job from the queue
      ST_IDLE: begin
        if (q_valid) begin
          q_pop        = 1'b1;
          d_nxt        = q_entry.day;
          m_nxt        = q_entry.month;
          y_nxt        = q_entry.year;
          yq_nxt       = q_entry.yq;
          yr_nxt       = q_entry.yr;
          rem_nxt      = q_entry.count;
          ok_nxt       = q_entry.ok;
          org_day_nxt  = q_entry.day;
          org_mon_nxt  = q_entry.month;
          org_year_nxt = q_entry.year;
          unique case (q_entry.kind)
            K_ADD:   st_nxt = ST_ADD;
            K_SUB:   st_nxt = ST_SUB;
            default: st_nxt = ST_EMIT;
          endcase
        end
      end

      // Forward: whole year from Jan 1, else to the first of next month, else finish
      ST_ADD: begin
        if (at_jan1 && (rem_r >= ylen)) begin
          if (y_r == MAX_Y) begin
            fail = 1'b1;
          end else begin
            y_nxt   = y_r + 1'b1;
            yq_nxt  = yq_inc;
            yr_nxt  = yr_inc;
            rem_nxt = rem_r - ylen;
          end
        end else if (rem_r >= to_next) begin
          rem_nxt = rem_r - to_next;
          d_nxt   = DAY_FIRST;
          if (m_r == MON_DEC) begin
            if (y_r == MAX_Y) begin
              fail = 1'b1;
            end else begin
              m_nxt  = MON_JAN;
              y_nxt  = y_r + 1'b1;
              yq_nxt = yq_inc;
              yr_nxt = yr_inc;
            end
          end else begin
            m_nxt = m_r + 1'b1;
          end
        end else begin
          d_nxt  = d_r + rem_r[DAY_W-1:0];
          ok_nxt = 1'b1;
          st_nxt = ST_EMIT;
        end
      end

      // Backward: whole year from Dec 31, else to the last of previous month, else finish
      ST_SUB: begin
        if (at_dec31 && (rem_r >= ylen)) begin
          if (y_r == MIN_YEAR) begin
            fail = 1'b1;
          end else begin
            y_nxt   = y_r - 1'b1;
            yq_nxt  = yq_dec;
            yr_nxt  = yr_dec;
            rem_nxt = rem_r - ylen;
          end
        end else if (rem_r >= to_prev) begin
          rem_nxt = rem_r - to_prev;
          if (m_r == MON_JAN) begin
            if (y_r == MIN_YEAR) begin
              fail = 1'b1;
            end else begin
              m_nxt  = MON_DEC;
              d_nxt  = DAY_LAST;
              y_nxt  = y_r - 1'b1;
              yq_nxt = yq_dec;
              yr_nxt = yr_dec;
            end
          end else begin
            m_nxt = m_r - 1'b1;
            d_nxt = dim_prev;
          end
        end else begin
          d_nxt  = d_r - rem_r[DAY_W-1:0];
          ok_nxt = 1'b1;
          st_nxt = ST_EMIT;
        end
      end

      // Hand the result to the output register once it is free
      ST_EMIT: begin
        if (!ov_r || out_ready) begin
          ov_nxt     = 1'b1;
          o_day_nxt  = d_r;
          o_mon_nxt  = m_r;
          o_year_nxt = y_r;
          o_ok_nxt   = ok_r;
          st_nxt     = ST_IDLE;
        end
      end

      default: st_nxt = ST_IDLE;
    endcase

    // Out of range: give the input date back, flagged invalid
    if (fail) begin
      d_nxt  = org_day_r;
      m_nxt  = org_mon_r;
      y_nxt  = org_year_r;
      ok_nxt = 1'b0;
      st_nxt = ST_EMIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r        <= d_nxt;
    m_r        <= m_nxt;
    y_r        <= y_nxt;
    yq_r       <= yq_nxt;
    yr_r       <= yr_nxt;
    rem_r      <= rem_nxt;
    ok_r       <= ok_nxt;
    org_day_r  <= org_day_nxt;
    org_mon_r  <= org_mon_nxt;
    org_year_r <= org_year_nxt;
    o_day_r    <= o_day_nxt;
    o_mon_r    <= o_mon_nxt;
    o_year_r   <= o_year_nxt;
    o_ok_r     <= o_ok_nxt;
  end

  assign out_valid = ov_r;
  assign out_day   = o_day_r;
  assign out_month = o_mon_r;
  assign out_year  = o_year_r;
  assign out_ok    = o_ok_r;

  `GDA_ASSERT_SAME(a_work_date_sane, (st_r == ST_ADD || st_r == ST_SUB), (yr_r <= YR_LAST && y_r >= MIN_YEAR && y_r <= MAX_Y && m_r >= MON_JAN && m_r <= MON_DEC && d_r >= DAY_FIRST), "work date left the valid calendar range")
  `GDA_ASSERT_SAME(a_rem_shrinks, (st_r == ST_ADD || st_r == ST_SUB) ##1 (st_r == ST_ADD || st_r == ST_SUB), (rem_r < $past(rem_r)), "stepping did not reduce the remaining day count")
  `GDA_ASSERT_NEXT(a_emit_holds, (st_r == ST_EMIT && ov_r && !out_ready), (st_r == ST_EMIT && $stable(d_r) && $stable(m_r) && $stable(y_r)), "pending result lost while output is blocked")
  `GDA_ASSERT_NEXT(a_pop_starts_job, q_pop, (st_r != ST_IDLE), "popped job was not started")

endmodule

/* sv/gregorian_date_arithmetic.sv */
// Gregorian date arithmetic: validate, next day, add or subtract a day count.
// Each input word gives exactly one result word, in order. A front end registers
// the word, then registers it again with year / 100, validates the date and
// classifies the job. A two-entry queue then feeds a back end that walks the
// date one month or one whole year per cycle. Reaching a year boundary takes
// at most 12 month steps. A count of 65535 then needs up to 179 whole-year
// steps, then at most 11 month steps and a final day step. The count keeps
// these maxima from falling together, so the worst case is about 197 steps.
// Beyond its steps, the back end spends an idle state taking each job and an
// emit state handing on the result, and its stepping loop sets the rate.
// Invalid input, or a result outside 1601-01-01 to MAX_YEAR-12-31, returns
// the input date with valid_res low.
module gregorian_date_arithmetic #(
  parameter int MAX_YEAR = 9999
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // day_in[4:0], month_in[8:5], year_in[22:9], day_count[38:23], zero[39]
  input  logic [gda_pkg::IN_TDATA_W-1:0]       in_tdata,
  // func[1:0]
  input  logic [gda_pkg::FUNC_W-1:0]           in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // day_out[4:0], month_out[8:5], year_out[22:9], zero[23]
  output logic [gda_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // valid_res[0]
  output logic [0:0]                           out_tuser
);
  import gda_pkg::*;

  logic                push_valid;
  logic                push_ready;
  entry_t              push_entry;
  logic                q_valid;
  logic                q_pop;
  entry_t              q_entry;
  logic [DAY_W-1:0]    out_day;
  logic [MON_W-1:0]    out_month;
  logic [YEAR_W-1:0]   out_year;
  logic                out_ok;

  gda_front #(
    .MAX_YEAR (MAX_YEAR)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_func    (func_t'(in_tuser)),
    .in_day     (in_tdata[4:0]),
    .in_month   (in_tdata[8:5]),
    .in_year    (in_tdata[22:9]),
    .in_count   (in_tdata[38:23]),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  gda_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_entry  (q_entry)
  );

  gda_back #(
    .MAX_YEAR (MAX_YEAR)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_day   (out_day),
    .out_month (out_month),
    .out_year  (out_year),
    .out_ok    (out_ok)
  );

  // Pack the result word
  assign out_tdata = {1'b0, out_year, out_month, out_day};
  assign out_tuser = out_ok;

endmodule
